// ===== design/ihp_pkg.sv =====
// ihp_pkg: shared types and constants for the IPv4 host text parser.
// No dependencies; imported by every ihp_* module and the top level.
package ihp_pkg;

    localparam int PART_W    = 33;
    localparam int NUM_PARTS = 4;
    localparam int ACC_W     = 64;
    localparam int OUT_W     = 40;

    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_X_LO = 8'h78;
    localparam logic [7:0] CH_X_UP = 8'h58;

    localparam logic [4:0] DIGIT_BAD = 5'd16;
    localparam logic [4:0] RADIX_OCT = 5'd8;
    localparam logic [4:0] RADIX_DEC = 5'd10;
    localparam logic [4:0] RADIX_HEX = 5'd16;

    localparam logic [2:0] COUNT_MAX = 3'd7;

    typedef logic [PART_W-1:0] part_val_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_ZERO,
        PH_HEX,
        PH_OCT,
        PH_DEC
    } phase_t;

    typedef enum logic [1:0] {
        PE_NONE,
        PE_EMPTY,
        PE_INVALID
    } part_err_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_TOO_MANY,
        ST_EMPTY,
        ST_INVALID,
        ST_OVERFLOW
    } status_t;

    // summary of one finished string, handed from scan to result stage
    typedef struct packed {
        logic [2:0] count;
        part_err_t  first_err;
        logic       seen_above_255;
        logic       trailing;
    } fin_t;

endpackage

// ===== design/ihp_scan.sv =====
// ihp_scan: per-character parse state, digit accumulate and part store.
// Depends on ihp_pkg. Produces the end-of-string summary for ihp_result.
module ihp_scan (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    take,
    input  logic [7:0]              ch,
    input  logic                    no_char,
    input  logic                    last,
    output logic                    fin_load,
    output ihp_pkg::fin_t           fin_next,
    output ihp_pkg::part_val_t [3:0] part_vals
);
    import ihp_pkg::*;

    logic [ACC_W-1:0] acc_reg;
    logic             wrap_reg;
    phase_t           phase_reg;
    logic             has_reg;
    logic             bad_reg;
    logic [2:0]       count_reg;
    part_err_t        first_err_reg;
    logic             seen_reg;
    part_val_t        pv_reg [NUM_PARTS];

    logic [ACC_W-1:0] acc_p;
    logic             wrap_p;
    phase_t           phase_p;
    logic             has_p;
    logic             bad_p;
    logic             feed;
    logic [4:0]       radix;
    logic [4:0]       digit;
    logic [ACC_W+3:0] acc_ext;
    logic [ACC_W+3:0] mul;
    logic [ACC_W+3:0] prod;
    logic             is_char;
    logic             dot;
    logic             trailing;
    logic             commit;
    part_err_t        err_p;
    part_err_t        first_err_next;
    logic             seen_next;
    logic [2:0]       count_next;
    part_val_t        cap_val;

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        d = DIGIT_BAD;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = 5'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = 5'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = 5'(c - 8'h41 + 8'd10);
        end
        return d;
    endfunction

    always_comb begin
        is_char = take && !no_char;
        dot     = is_char && (ch == CH_DOT);
        acc_p   = acc_reg;
        wrap_p  = wrap_reg;
        phase_p = phase_reg;
        has_p   = has_reg;
        bad_p   = bad_reg;
        feed    = 1'b0;
        radix   = RADIX_DEC;
        if (is_char && !dot) begin
            has_p = 1'b1;
            case (phase_reg)
                PH_START: begin
                    if (ch == CH_ZERO) begin
                        phase_p = PH_ZERO;
                    end else begin
                        phase_p = PH_DEC;
                        feed    = 1'b1;
                    end
                end
                PH_ZERO: begin
                    if (ch == CH_X_LO || ch == CH_X_UP) begin
                        phase_p = PH_HEX;
                    end else begin
                        phase_p = PH_OCT;
                        feed    = 1'b1;
                        radix   = RADIX_OCT;
                    end
                end
                PH_HEX: begin
                    feed  = 1'b1;
                    radix = RADIX_HEX;
                end
                PH_OCT: begin
                    feed  = 1'b1;
                    radix = RADIX_OCT;
                end
                default: begin
                    feed = 1'b1;
                end
            endcase
        end

        digit   = digit_of(ch);
        acc_ext = {4'b0000, acc_reg};
        case (radix)
            RADIX_HEX: mul = acc_ext << 4;
            RADIX_OCT: mul = acc_ext << 3;
            default:   mul = (acc_ext << 3) + (acc_ext << 1);
        endcase
        prod = mul + {{(ACC_W-1){1'b0}}, digit};

        if (feed) begin
            if (digit >= radix) begin
                bad_p = 1'b1;
            end else begin
                acc_p = prod[ACC_W-1:0];
                if (prod[ACC_W+3:ACC_W] != 4'd0) begin
                    wrap_p = 1'b1;
                end
            end
        end

        // a dot on the final transfer closes a part and leaves a trailing empty one
        trailing = take && last && (dot || (!has_p && count_reg != 3'd0));
        commit   = dot || (take && last && !trailing);

        if (!has_p) begin
            err_p = PE_EMPTY;
        end else if (bad_p || wrap_p) begin
            err_p = PE_INVALID;
        end else begin
            err_p = PE_NONE;
        end

        first_err_next = first_err_reg;
        seen_next      = seen_reg;
        count_next     = count_reg;
        if (commit) begin
            if (first_err_reg == PE_NONE) begin
                first_err_next = err_p;
            end
            if (err_p == PE_NONE && acc_p[ACC_W-1:8] != '0) begin
                seen_next = 1'b1;
            end
            if (count_reg != COUNT_MAX) begin
                count_next = count_reg + 3'd1;
            end
        end

        cap_val = (acc_p[ACC_W-1:32] != '0) ? {1'b1, 32'd0} : {1'b0, acc_p[31:0]};

        fin_load                = take && last;
        fin_next.count          = count_next;
        fin_next.first_err      = first_err_next;
        fin_next.seen_above_255 = seen_next;
        fin_next.trailing       = trailing;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && last)) begin
            acc_reg       <= '0;
            wrap_reg      <= 1'b0;
            phase_reg     <= PH_START;
            has_reg       <= 1'b0;
            bad_reg       <= 1'b0;
            count_reg     <= '0;
            first_err_reg <= PE_NONE;
            seen_reg      <= 1'b0;
        end else if (take) begin
            count_reg     <= count_next;
            first_err_reg <= first_err_next;
            seen_reg      <= seen_next;
            if (commit) begin
                acc_reg   <= '0;
                wrap_reg  <= 1'b0;
                phase_reg <= PH_START;
                has_reg   <= 1'b0;
                bad_reg   <= 1'b0;
            end else begin
                acc_reg   <= acc_p;
                wrap_reg  <= wrap_p;
                phase_reg <= phase_p;
                has_reg   <= has_p;
                bad_reg   <= bad_p;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (commit && err_p == PE_NONE && !count_reg[2]) begin
            pv_reg[count_reg[1:0]] <= cap_val;
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_PARTS; i++) begin
            part_vals[i] = pv_reg[i];
        end
    end

endmodule

// ===== design/ihp_result.sv =====
// ihp_result: end-of-string summary register, status/address assembly and
// output register. Depends on ihp_pkg; reads the part store of ihp_scan.
module ihp_result (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     fin_load,
    input  ihp_pkg::fin_t            fin_next,
    input  ihp_pkg::part_val_t [3:0] part_vals,
    output logic                     fin_ready,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [ihp_pkg::OUT_W-1:0] m_tdata
);
    import ihp_pkg::*;

    logic             fin_valid_reg;
    fin_t             fin_reg;
    logic             m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;

    logic             fin_move;
    status_t          status;
    logic             ovf;
    logic [31:0]      address;
    logic [31:0]      addr_raw;
    logic             verr;

    assign fin_move  = fin_valid_reg && (!m_valid_reg || m_tready);
    assign fin_ready = !fin_valid_reg || !m_valid_reg || m_tready;

    always_comb begin
        ovf      = 1'b0;
        addr_raw = '0;
        case (fin_reg.count)
            3'd1: begin
                ovf      = part_vals[0][32];
                addr_raw = part_vals[0][31:0];
            end
            3'd2: begin
                ovf      = (part_vals[0][32:8] != '0) || (part_vals[1][32:24] != '0);
                addr_raw = {part_vals[0][7:0], part_vals[1][23:0]};
            end
            3'd3: begin
                ovf      = (part_vals[0][32:8] != '0) || (part_vals[1][32:8] != '0)
                        || (part_vals[2][32:16] != '0);
                addr_raw = {part_vals[0][7:0], part_vals[1][7:0], part_vals[2][15:0]};
            end
            3'd4: begin
                ovf      = (part_vals[0][32:8] != '0) || (part_vals[1][32:8] != '0)
                        || (part_vals[2][32:8] != '0) || (part_vals[3][32:8] != '0);
                addr_raw = {part_vals[0][7:0], part_vals[1][7:0],
                            part_vals[2][7:0], part_vals[3][7:0]};
            end
            default: begin
                ovf = 1'b1;
            end
        endcase

        if (fin_reg.count > 3'd4) begin
            status = ST_TOO_MANY;
        end else if (fin_reg.first_err == PE_EMPTY) begin
            status = ST_EMPTY;
        end else if (fin_reg.first_err == PE_INVALID) begin
            status = ST_INVALID;
        end else if (ovf) begin
            status = ST_OVERFLOW;
        end else begin
            status = ST_OK;
        end

        address = (status == ST_OK) ? addr_raw : 32'd0;
        verr    = (status != ST_OK) || fin_reg.trailing || fin_reg.seen_above_255;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (fin_load) begin
                fin_valid_reg <= 1'b1;
            end else if (fin_move) begin
                fin_valid_reg <= 1'b0;
            end
            if (fin_move) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_load) begin
            fin_reg <= fin_next;
        end
        if (fin_move) begin
            m_data_reg <= {4'b0000, verr, status, address};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== design/ipv4_host_text_parser.sv =====
// ipv4_host_text_parser: top level, parses dotted host text into an IPv4 address.
// Depends on ihp_pkg, ihp_scan and ihp_result.
//
//  channel | dir | tdata (low bit up)                          | tuser    | tlast
//  s_      | in  | ch[7:0]                                     | no_char  | last
//  m_      | out | address[31:0], status[34:32], verr[35], pad | -        | -
//
// One character transfer per cycle while s_tready is high; the scan state updates on acceptance.
// The result of the transfer with tlast set passes through the summary register
// and then the output register.
// s_tready drops only while both the summary and output registers hold
// results and m_tready is low.
// aresetn is synchronous, active low, and clears all control state.
module ipv4_host_text_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch[7:0]
    input  logic [0:0]  s_tuser,   // no_char
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // address[31:0], status[34:32], verr[35], zeros
);
    import ihp_pkg::*;

    logic                 take;
    logic                 fin_load;
    fin_t                 fin_next;
    part_val_t [3:0]      part_vals;
    logic                 fin_ready;

    assign s_tready = fin_ready;
    assign take     = s_tvalid && fin_ready;

    ihp_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .ch        (s_tdata),
        .no_char   (s_tuser[0]),
        .last      (s_tlast),
        .fin_load  (fin_load),
        .fin_next  (fin_next),
        .part_vals (part_vals)
    );

    ihp_result u_result (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fin_load  (fin_load),
        .fin_next  (fin_next),
        .part_vals (part_vals),
        .fin_ready (fin_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== design/ihp_checker.sv =====
// ihp_checker: port-level checks for ipv4_host_text_parser, bound to the top level.
// Depends on ihp_pkg for status codes.
module ihp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic [0:0]  s_tuser,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
    import ihp_pkg::*;

    a_m_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_m_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_err_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[34:32] != ST_OK |-> m_tdata[31:0] == 32'd0 && m_tdata[35])
        else $error("error result with address or without validation flag");

    // summary register, then output register
    a_result_follows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result without a preceding end-of-string transfer");

endmodule

bind ipv4_host_text_parser ihp_checker u_ihp_checker (.*);
